// ===== hdl/srpg_pkg.sv =====
// ----------------------------------------------------------------------------
// srpg_pkg
// Shared constants, types and register map of the sparse row pattern grouper.
// ----------------------------------------------------------------------------
`default_nettype none

package srpg_pkg;

  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_ROWS    = 1024;

  localparam int COL_W   = 10;
  localparam int BLK_W   = 10;
  localparam int BSZ_W   = 11;
  localparam int HASH_W  = 20;
  localparam int GRP_W   = 10;
  localparam int ADDR_W  = $clog2(MAX_COLUMNS);
  localparam int POS_W   = ADDR_W + 1;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam int DIV_STEPS = COL_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  localparam logic [HASH_W-1:0] HASH_TOP = {HASH_W{1'b1}};
  localparam int GROUP_TOP_INT = (MAX_ROWS - 1 > 1023) ? 1023 : MAX_ROWS - 1;
  localparam logic [GRP_W-1:0] GROUP_TOP = GRP_W'(GROUP_TOP_INT);

  // register index = paddr[2]
  localparam logic REG_BLOCK_SIZE = 1'b0;
  localparam logic REG_MODE       = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic             start;
    logic [COL_W-1:0] dividend;
    logic [BSZ_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [BLK_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/srpg_in_if.sv =====
// ----------------------------------------------------------------------------
// srpg_in_if
// Input channel: one column index of a sparse row per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface srpg_in_if;
  logic                       valid;
  logic                       ready;
  logic [srpg_pkg::COL_W-1:0] column_index;
  logic                       row_end;
  logic                       row_empty;
  logic                       new_matrix;

  modport source (output valid, column_index, row_end, row_empty, new_matrix,
                  input ready);
  modport sink   (input valid, column_index, row_end, row_empty, new_matrix,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/srpg_out_if.sv =====
// ----------------------------------------------------------------------------
// srpg_out_if
// Output channel: one result per finished row.
// ----------------------------------------------------------------------------
`default_nettype none

interface srpg_out_if;
  logic                        valid;
  logic                        ready;
  logic [srpg_pkg::HASH_W-1:0] row_hash;
  logic [srpg_pkg::GRP_W-1:0]  group_id;
  logic                        same_pattern;

  modport source (output valid, row_hash, group_id, same_pattern, input ready);
  modport sink   (input valid, row_hash, group_id, same_pattern, output ready);
endinterface

`default_nettype wire

// ===== hdl/srpg_divider.sv =====
// ----------------------------------------------------------------------------
// srpg_divider
// Restoring divider, one quotient bit per cycle: column index / block size.
// ----------------------------------------------------------------------------
`default_nettype none

module srpg_divider (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire srpg_pkg::div_req_t req,
  output srpg_pkg::div_rsp_t      rsp
);
  import srpg_pkg::*;

  logic [BSZ_W-1:0]  rem;
  logic [BSZ_W-1:0]  divisor;
  logic [COL_W-1:0]  quo;
  logic [DCNT_W-1:0] cnt;
  logic              busy;
  logic              done;

  logic [BSZ_W:0]    trial;
  logic              fits;

  assign trial = {rem, quo[COL_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= req.dividend;
      rem     <= '0;
      cnt     <= DCNT_W'(DIV_STEPS - 1);
      divisor <= (req.divisor == '0) ? BSZ_W'(1) : req.divisor;
    end else if (busy) begin
      // shift in the next dividend bit, subtract when the divisor fits
      if (fits) begin
        rem <= BSZ_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[BSZ_W-1:0];
      end
      quo <= {quo[COL_W-2:0], fits};
      cnt <= cnt - DCNT_W'(1);
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

// ===== hdl/sparse_row_pattern_grouper.sv =====
// ----------------------------------------------------------------------------
// sparse_row_pattern_grouper
// Groups consecutive sparse rows whose block patterns match.
// ----------------------------------------------------------------------------
//  channel    dir  handshake      payload
//  in_items   in   valid/ready    column_index, row_end, row_empty, new_matrix
//  out_rows   out  valid/ready    row_hash, group_id, same_pattern
//  apb        in   psel/penable   block size (0x0), mode (0x4)
//
//  A nonzero index goes through the transfer, ten steps of the shared
//  divider, and one read-modify-write of the pattern memory. A row end
//  then loads the result register in the finish state; so does an empty row.
//  Reset is synchronous; the pattern memory needs no clearing pass.
//  A stalled result holds the block in its finish state; input waits then.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_row_pattern_grouper (
  input  wire logic                         clk,
  input  wire logic                         rst,
  srpg_in_if.sink                           in_items,
  srpg_out_if.source                        out_rows,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [srpg_pkg::PADDR_W-1:0] paddr,
  input  wire logic [srpg_pkg::PDATA_W-1:0] pwdata,
  output logic      [srpg_pkg::PDATA_W-1:0] prdata,
  output logic                              pready
);
  import srpg_pkg::*;

  // configuration
  logic [BSZ_W-1:0] bsize;
  logic             mode;

  // state
  state_t            state, state_next;
  logic [BLK_W-1:0]  prev_blocks [MAX_COLUMNS];
  logic [BLK_W-1:0]  rd_data;
  logic [POS_W-1:0]  prev_len;
  logic [POS_W-1:0]  cur_pos;
  logic [BLK_W-1:0]  last_blk;
  logic              blk_seen;
  logic [HASH_W-1:0] hash;
  logic              mismatch;
  logic [GRP_W-1:0]  group;
  logic              have_prev;
  logic              row_end_q;

  // result register
  logic              out_valid;
  logic [HASH_W-1:0] out_hash;
  logic [GRP_W-1:0]  out_group;
  logic              out_same;

  // control
  logic     in_xfer;
  logic     step_done;
  logic     out_load;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // datapath
  logic [BLK_W-1:0]  blk;
  logic              counted;
  logic              store;
  logic [HASH_W:0]   hash_sum;
  logic              same;
  logic [GRP_W-1:0]  group_next;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bsize <= BSZ_W'(1);
      mode  <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_BLOCK_SIZE: bsize <= pwdata[BSZ_W-1:0];
        REG_MODE:       mode  <= pwdata[0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BLOCK_SIZE: prdata = {{(PDATA_W-BSZ_W){1'b0}}, bsize};
      REG_MODE:       prdata = {{(PDATA_W-1){1'b0}}, mode};
      default:        prdata = '0;
    endcase
  end

  // ---------------- divider ----------------
  assign div_req.start    = in_xfer && !in_items.row_empty;
  assign div_req.dividend = in_items.column_index;
  assign div_req.divisor  = bsize;

  srpg_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // ---------------- control ----------------
  assign in_items.ready = (state == ST_IDLE);
  assign in_xfer        = in_items.valid && in_items.ready;

  always_comb begin
    state_next = state;
    step_done  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          state_next = in_items.row_empty ? ST_FINISH : ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_rsp.done) begin
          step_done  = 1'b1;
          state_next = row_end_q ? ST_FINISH : ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_rows.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------- pattern memory ----------------
  // read port follows the current position; data is ready long before the
  // divider finishes
  assign blk      = div_rsp.quotient;
  assign counted  = mode || !(blk_seen && blk == last_blk);
  assign store    = step_done && counted && !cur_pos[ADDR_W];
  assign hash_sum = {1'b0, hash} + {{(HASH_W-BLK_W+1){1'b0}}, blk};

  always_ff @(posedge clk) begin
    rd_data <= prev_blocks[cur_pos[ADDR_W-1:0]];
    if (store) begin
      prev_blocks[cur_pos[ADDR_W-1:0]] <= blk;
    end
  end

  // ---------------- row end ----------------
  assign same = have_prev && !mismatch && (cur_pos == prev_len);

  always_comb begin
    if (!have_prev) begin
      group_next = '0;
    end else if (!same && group < GROUP_TOP) begin
      group_next = group + GRP_W'(1);
    end else begin
      group_next = group;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_len  <= '0;
      cur_pos   <= '0;
      last_blk  <= '0;
      blk_seen  <= 1'b0;
      hash      <= '0;
      mismatch  <= 1'b0;
      group     <= '0;
      have_prev <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_xfer && in_items.new_matrix) begin
        // drop any partial row and restart grouping
        have_prev <= 1'b0;
        group     <= '0;
        cur_pos   <= '0;
        last_blk  <= '0;
        blk_seen  <= 1'b0;
        hash      <= '0;
        mismatch  <= 1'b0;
      end

      if (step_done) begin
        last_blk <= blk;
        blk_seen <= 1'b1;
        if (counted) begin
          hash <= hash_sum[HASH_W] ? HASH_TOP : hash_sum[HASH_W-1:0];
          if (cur_pos[ADDR_W]) begin
            mismatch <= 1'b1;
          end else begin
            if (cur_pos >= prev_len || rd_data != blk) begin
              mismatch <= 1'b1;
            end
            cur_pos <= cur_pos + POS_W'(1);
          end
        end
      end

      if (out_load) begin
        out_valid <= 1'b1;
        group     <= group_next;
        prev_len  <= cur_pos;
        have_prev <= 1'b1;
        cur_pos   <= '0;
        last_blk  <= '0;
        blk_seen  <= 1'b0;
        hash      <= '0;
        mismatch  <= 1'b0;
      end else if (out_rows.valid && out_rows.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      row_end_q <= in_items.row_end;
    end
    if (out_load) begin
      out_hash  <= hash;
      out_group <= group_next;
      out_same  <= same;
    end
  end

  assign out_rows.valid        = out_valid;
  assign out_rows.row_hash     = out_hash;
  assign out_rows.group_id     = out_group;
  assign out_rows.same_pattern = out_same;

`ifndef SYNTHESIS
  a_div_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == ST_DIVIDE)
    else $error("divider finished outside the divide state");

  a_pos_bounded: assert property (@(posedge clk) disable iff (rst)
    cur_pos <= POS_W'(MAX_COLUMNS))
    else $error("row position ran past the pattern memory");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || out_rows.ready))
    else $error("result register loaded while a result waits");

  a_empty_row_finishes: assert property (@(posedge clk) disable iff (rst)
    in_xfer && in_items.row_empty |=> state == ST_FINISH)
    else $error("empty row did not go straight to finish");
`endif

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Regression bench for the sparse row pattern grouper: directed edge rows,
// random row streams under changing block size and mode, and a long output
// stall. Every finished row is checked field by field against a cycle-free
// prediction of the grouping rules.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srpg_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS  = 400;
  localparam int MAX_GAP       = 14;
  localparam int PRINT_CAP     = 100;
  localparam int HOLD_CYCLES   = 300;

  typedef struct packed {
    logic [HASH_W-1:0] row_hash;
    logic [GRP_W-1:0]  group_id;
    logic              same_pattern;
  } row_result_t;

  typedef logic [COL_W-1:0] col_list_t[$];

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  srpg_in_if  in_ch();
  srpg_out_if out_ch();

  sparse_row_pattern_grouper dut (
    .clk      (clk),
    .rst      (rst),
    .in_items (in_ch),
    .out_rows (out_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #1 clk = ~clk;

  // Predicted block state
  logic [BLK_W-1:0] pattern_store [MAX_COLUMNS];
  int               pattern_len;
  int               row_pos;
  int               row_hash_acc;
  logic [BLK_W-1:0] last_block;
  bit               block_valid;
  bit               row_differs;
  bit               have_prev_row;
  logic [GRP_W-1:0] group_no;
  logic [BSZ_W-1:0] cfg_bsz;
  bit               cfg_mode;

  row_result_t expected_rows[$];
  int          errors      = 0;
  int          n_items     = 0;
  int          n_results   = 0;
  int          n_writes    = 0;
  int          cycle_count = 0;
  bit          idle_on     = 1'b1;
  bit          hold_results = 1'b0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("sparse_row_pattern_grouper regression: fail");
      $finish;
    end
  end

  function automatic void clear_row_state();
    row_pos      = 0;
    last_block   = '0;
    block_valid  = 1'b0;
    row_hash_acc = 0;
    row_differs  = 1'b0;
  endfunction

  function automatic void reset_grouper_state();
    cfg_bsz        = BSZ_W'(1);
    cfg_mode       = 1'b0;
    pattern_len    = 0;
    group_no       = '0;
    have_prev_row  = 1'b0;
    clear_row_state();
  endfunction

  function automatic void absorb_column(input logic [COL_W-1:0] col);
    int               divisor;
    logic [BLK_W-1:0] blk;
    bit               counted;
    divisor = (cfg_bsz == '0) ? 1 : int'(cfg_bsz);
    blk     = BLK_W'(int'(col) / divisor);
    counted = cfg_mode || !(block_valid && blk == last_block);
    last_block  = blk;
    block_valid = 1'b1;
    if (!counted) return;
    row_hash_acc += int'(blk);
    if (row_hash_acc > int'(HASH_TOP)) row_hash_acc = int'(HASH_TOP);
    // past the store: drop the entry, pin the position, force a difference
    if (row_pos >= MAX_COLUMNS) begin
      row_differs = 1'b1;
      return;
    end
    if (row_pos >= pattern_len || pattern_store[row_pos] != blk) row_differs = 1'b1;
    pattern_store[row_pos] = blk;
    row_pos++;
  endfunction

  function automatic bit predict_row_result(input logic [COL_W-1:0] col,
                                            input logic row_end, input logic row_empty,
                                            input logic new_matrix,
                                            output row_result_t res);
    bit same;
    res = '0;
    if (new_matrix) begin
      have_prev_row = 1'b0;
      group_no      = '0;
      clear_row_state();
    end
    if (!row_empty) absorb_column(col);
    if (!row_end && !row_empty) return 1'b0;
    if (have_prev_row) begin
      same = !row_differs && row_pos == pattern_len;
      if (!same && group_no < GROUP_TOP) group_no++;
    end else begin
      same     = 1'b0;
      group_no = '0;
    end
    res.row_hash     = HASH_W'(row_hash_acc);
    res.group_id     = group_no;
    res.same_pattern = same;
    pattern_len   = row_pos;
    have_prev_row = 1'b1;
    clear_row_state();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= PRINT_CAP) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task automatic send_item(input logic [COL_W-1:0] col, input logic row_end,
                           input logic row_empty, input logic new_matrix);
    int          gap;
    row_result_t res;
    gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.column_index <= col;
    in_ch.row_end      <= row_end;
    in_ch.row_empty    <= row_empty;
    in_ch.new_matrix   <= new_matrix;
    do @(posedge clk); while (!in_ch.ready);
    n_items++;
    if (predict_row_result(col, row_end, row_empty, new_matrix, res))
      expected_rows.insert(expected_rows.size(), res);
  endtask

  task automatic send_row(input col_list_t cols, input bit start_matrix, input bit cut_short);
    if (cols.size() == 0) begin
      send_item(COL_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)), 1'b1,
                start_matrix);
    end else begin
      foreach (cols[i])
        send_item(cols[i], (i == cols.size() - 1) && !cut_short, 1'b0,
                  start_matrix && i == 0);
    end
  endtask

  // Check and count every result transfer
  initial begin : result_checker
    int          gap;
    row_result_t want;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0 || hold_results) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
        while (hold_results) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      n_results++;
      if (expected_rows.size() == 0) begin
        report_mismatch($sformatf("row result with no row pending (hash %0d)",
                                  out_ch.row_hash));
      end else begin
        want = expected_rows.pop_front();
        if (out_ch.row_hash !== want.row_hash)
          report_mismatch($sformatf("row_hash %0d, expected %0d",
                                    out_ch.row_hash, want.row_hash));
        if (out_ch.group_id !== want.group_id)
          report_mismatch($sformatf("group_id %0d, expected %0d",
                                    out_ch.group_id, want.group_id));
        if (out_ch.same_pattern !== want.same_pattern)
          report_mismatch($sformatf("same_pattern %0b, expected %0b",
                                    out_ch.same_pattern, want.same_pattern));
      end
    end
  end

  // Stop offering input, wait for every pending row, then let the block go idle
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic write, input logic reg_idx,
                            input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= PADDR_W'({reg_idx, 2'b00});
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_register(input logic reg_idx);
    logic [PDATA_W-1:0] rd;
    logic [PDATA_W-1:0] want;
    apb_access(1'b0, reg_idx, '0, rd);
    want = (reg_idx == REG_BLOCK_SIZE) ? PDATA_W'(cfg_bsz) : PDATA_W'(cfg_mode);
    if (rd !== want)
      report_mismatch($sformatf("register %0d reads %0d, expected %0d", reg_idx, rd, want));
  endtask

  task automatic set_register(input logic reg_idx, input int value);
    logic [PDATA_W-1:0] rd;
    settle_block();
    apb_access(1'b1, reg_idx, PDATA_W'(value), rd);
    n_writes++;
    if (reg_idx == REG_BLOCK_SIZE) cfg_bsz = BSZ_W'(value);
    else cfg_mode = value[0];
    @(posedge clk);
    check_register(reg_idx);
  endtask

  task automatic test_register_reset();
    check_register(REG_BLOCK_SIZE);
    @(posedge clk);
    check_register(REG_MODE);
  endtask

  task automatic test_directed_rows();
    // block size 1, mode 0 from reset
    send_item(10'd0, 1'b1, 1'b0, 1'b1);      // first row of a matrix
    send_item(10'd0, 1'b1, 1'b0, 1'b0);      // same pattern
    send_item(10'd1023, 1'b1, 1'b0, 1'b0);   // top column, new group
    send_item(10'd1023, 1'b0, 1'b1, 1'b0);   // empty row, column ignored
    send_item(10'd0, 1'b0, 1'b1, 1'b0);      // empty after empty matches
    send_item(10'd512, 1'b1, 1'b1, 1'b0);    // end together with empty
    send_item(10'd3, 1'b0, 1'b0, 1'b0);      // partial row ...
    send_item(10'd7, 1'b1, 1'b0, 1'b1);      // ... dropped by a new matrix
    send_item(10'd5, 1'b0, 1'b0, 1'b0);      // repeated block counted once
    send_item(10'd5, 1'b1, 1'b0, 1'b0);
    set_register(REG_BLOCK_SIZE, 4);
    set_register(REG_MODE, 1);
    send_item(10'd4, 1'b0, 1'b0, 1'b0);
    send_item(10'd5, 1'b1, 1'b0, 1'b0);
    send_item(10'd6, 1'b0, 1'b0, 1'b0);
    send_item(10'd7, 1'b1, 1'b0, 1'b0);
    set_register(REG_MODE, 0);
    send_item(10'd4, 1'b0, 1'b0, 1'b0);
    send_item(10'd7, 1'b0, 1'b0, 1'b0);
    send_item(10'd8, 1'b1, 1'b0, 1'b0);
    set_register(REG_BLOCK_SIZE, 0);         // zero acts as one
    send_item(10'd1023, 1'b1, 1'b0, 1'b0);
    send_item(10'd9, 1'b1, 1'b1, 1'b1);      // empty first row of a matrix
    set_register(REG_BLOCK_SIZE, 2047);      // everything lands in block 0
    send_item(10'd1023, 1'b1, 1'b0, 1'b0);
    set_register(REG_BLOCK_SIZE, 1024);
    send_item(10'd1023, 1'b0, 1'b0, 1'b0);
    send_item(10'd0, 1'b1, 1'b0, 1'b0);
  endtask

  task automatic pick_random_config();
    int bsz;
    case ($urandom_range(0, 7))
      0: bsz = 0;
      1: bsz = 1;
      2: bsz = 2047;
      3: bsz = 1024;
      4: bsz = $urandom_range(2, 16);
      5: bsz = $urandom_range(1, 2047);
      default: bsz = $urandom_range(1, 64);
    endcase
    set_register(REG_BLOCK_SIZE, bsz);
    set_register(REG_MODE, $urandom_range(0, 1));
  endtask

  task automatic test_random_rows();
    col_list_t prev_cols;
    col_list_t cols;
    int        start_items;
    int        next_cfg;
    int        pick;
    int        len;
    int        base;
    int        k;
    bit        nm;
    bit        cut;
    bit        cut_pending;
    start_items = n_items;
    next_cfg    = 0;
    cut_pending = 1'b0;
    while (n_items - start_items < RANDOM_ITEMS) begin
      if (n_items - start_items >= next_cfg) begin
        pick_random_config();
        next_cfg += 50 + $urandom_range(0, 40);
      end
      if ($urandom_range(0, 9) == 0) idle_on = !idle_on;
      pick = $urandom_range(0, 99);
      cols = prev_cols;
      if (pick < 35) begin
        // repeat the previous pattern
      end else if (pick < 50 && cols.size() > 0) begin
        k = $urandom_range(0, cols.size() - 1);
        cols[k] = $urandom_range(0, 1) ? cols[k] + 1 : cols[k] - 1;
      end else if (pick < 85) begin
        cols = {};
        len  = $urandom_range(1, 8);
        base = $urandom_range(0, 1023);
        repeat (len) begin
          if ($urandom_range(0, 1)) cols.insert(cols.size(), COL_W'($urandom_range(0, 1023)));
          else cols.insert(cols.size(), COL_W'((base + $urandom_range(0, 15) > 1023) ? 1023 :
                                               base + $urandom_range(0, 15)));
        end
        cols.sort();
      end else if (pick < 93) begin
        cols = {};
      end else begin
        // unordered noise
        cols = {};
        len  = $urandom_range(1, 6);
        repeat (len) cols.insert(cols.size(), COL_W'($urandom_range(0, 1023)));
      end
      nm  = ($urandom_range(0, 19) == 0) || cut_pending;
      cut = (cols.size() > 0) && ($urandom_range(0, 19) == 0);
      send_row(cols, nm, cut);
      // a cut row either merges into the next row or is dropped by a new matrix
      cut_pending = cut && $urandom_range(0, 1);
      prev_cols   = cols;
    end
    idle_on = 1'b1;
  endtask

  task automatic test_result_backpressure();
    set_register(REG_BLOCK_SIZE, 1);
    set_register(REG_MODE, 0);
    idle_on = 1'b0;
    fork
      begin
        hold_results = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end
      for (int k = 0; k < 30; k++)
        send_item(COL_W'($urandom_range(0, 1023)), 1'b1, k % 4 == 3, k == 0);
    join
    idle_on = 1'b1;
  endtask

  initial begin
    rst                <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.column_index <= '0;
    in_ch.row_end      <= 1'b0;
    in_ch.row_empty    <= 1'b0;
    in_ch.new_matrix   <= 1'b0;
    reset_grouper_state();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_register_reset();
    test_directed_rows();
    test_random_rows();
    test_result_backpressure();
    settle_block();
    $display("run: %0d input transfers, %0d row results, %0d register writes, %0d mismatches",
             n_items, n_results, n_writes, errors);
    $display("covered: edge rows, random row streams over many block sizes and both modes,");
    $display("         and a long output stall that fills the block");
    if (errors == 0) begin
      $display("sparse_row_pattern_grouper regression: pass");
    end else begin
      $display("sparse_row_pattern_grouper regression: fail");
    end
    $finish;
  end

endmodule

// ===== sparse_row_pattern_grouper.f =====
hdl/srpg_pkg.sv
hdl/srpg_in_if.sv
hdl/srpg_out_if.sv
hdl/srpg_divider.sv
hdl/sparse_row_pattern_grouper.sv
verif/tb.sv
